>>> design/assert_macros.svh
// Assertion helpers for the RTL files; cbm_back includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CBM_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define CBM_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> design/cbm_pkg.sv
// ----------------------------------------------------------------------------
// cbm_pkg
// Types, codes and address helpers of the cache and bus timing model.
// ----------------------------------------------------------------------------
package cbm_pkg;

    localparam int MAX_LINES   = 512;
    localparam int IDX_W       = $clog2(MAX_LINES);
    localparam int MAX_MODULES = 4;
    localparam int MOD_W       = $clog2(MAX_MODULES);
    localparam int TAG_W       = 30;
    localparam int BUSY_W      = 5;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_STORE = 2'd2;
    localparam logic [1:0] OP_FETCH = 2'd3;

    localparam logic [1:0] ST_CLEAR   = 2'd0;
    localparam logic [1:0] ST_READY   = 2'd1;
    localparam logic [1:0] ST_PENDING = 2'd2;
    localparam logic [1:0] ST_BLOCKED = 2'd3;

    localparam logic [2:0] CFG_DEN   = 3'd0;
    localparam logic [2:0] CFG_IEN   = 3'd1;
    localparam logic [2:0] CFG_LINE  = 3'd2;
    localparam logic [2:0] CFG_DBITS = 3'd3;
    localparam logic [2:0] CFG_IBITS = 3'd4;
    localparam logic [2:0] CFG_MBITS = 3'd5;
    localparam logic [2:0] CFG_MLAT  = 3'd6;
    localparam logic [2:0] CFG_PLAT  = 3'd7;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] addr;
    } t_item;

    typedef struct packed {
        logic pop;
        logic clearing;
    } t_bk_ctrl;

    typedef struct packed {
        logic [31:0] addr;
        logic [1:0]  status;
        logic [15:0] req;
    } t_entry;

    function automatic logic [TAG_W-1:0] line_of(logic [31:0] a, logic [2:0] lb);
        logic [2:0] e;
        e = (lb < 3'd2) ? 3'd2 : lb;
        line_of = TAG_W'(a >> e);
    endfunction

    // Module number mask: the interleave factor saturates at MAX_MODULES.
    function automatic logic [MOD_W-1:0] mod_mask(logic [1:0] mb);
        logic [3:0] full;
        full = 4'((5'd1 << mb) - 5'd1);
        mod_mask = (full > 4'(MAX_MODULES - 1)) ? MOD_W'(MAX_MODULES - 1) : MOD_W'(full);
    endfunction

    function automatic logic [IDX_W-1:0] cache_idx(logic [TAG_W-1:0] line,
                                                   logic [3:0] bits);
        logic [15:0] m;
        m = 16'((17'd1 << bits) - 17'd1);
        cache_idx = line[IDX_W-1:0] & m[IDX_W-1:0];
    endfunction

endpackage

>>> design/cbm_front.sv
// ----------------------------------------------------------------------------
// cbm_front
// Input side: takes stream transfers, turns each into one item and queues them.
// ----------------------------------------------------------------------------
module cbm_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [39:0]      i_s_axis_tdata,
    input  cbm_pkg::t_bk_ctrl i_ctrl,
    output logic             o_hd_valid,
    output cbm_pkg::t_item   o_hd
);
    import cbm_pkg::*;

    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push;
    t_item      in_item;

    assign in_item.op   = i_s_axis_tdata[1:0];
    assign in_item.addr = i_s_axis_tdata[33:2];

    assign o_s_axis_tready = (r_cnt != 2'd2) && !i_ctrl.clearing;
    assign push            = i_s_axis_tvalid && o_s_axis_tready;
    assign o_hd_valid      = (r_cnt != 2'd0);
    assign o_hd            = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_ctrl.pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_ctrl.pop);
        end
    end

endmodule

>>> design/cbm_back.sv
// ----------------------------------------------------------------------------
// cbm_back
// Execution side: cache tag lookups, buffers, bus arbitration and modules.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cbm_back #(
    parameter int WB_ENTRIES = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [4:0]        i_cfg_data,
    input  logic              i_hd_valid,
    input  cbm_pkg::t_item    i_hd,
    output cbm_pkg::t_bk_ctrl o_ctrl,
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [39:0]       o_m_axis_tdata
);
    import cbm_pkg::*;

    localparam int WB_IDX_W = $clog2(WB_ENTRIES + 1);
    localparam int WIN_W    = $clog2(MAX_MODULES + 4);

    localparam logic [1:0] S_CLR  = 2'd0;
    localparam logic [1:0] S_IDLE = 2'd1;
    localparam logic [1:0] S_LOOK = 2'd2;

    localparam logic [WIN_W-1:0] WIN_NONE  = WIN_W'(0);
    localparam logic [WIN_W-1:0] WIN_READ  = WIN_W'(1);
    localparam logic [WIN_W-1:0] WIN_WRITE = WIN_W'(2);
    localparam logic [WIN_W-1:0] WIN_FETCH = WIN_W'(3);
    localparam logic [WIN_W-1:0] WIN_MOD0  = WIN_W'(4);

    localparam logic DIR_TO_CPU = 1'b0;
    localparam logic DIR_TO_MEM = 1'b1;

    // Configuration.
    logic       r_den, r_ien;
    logic [2:0] r_lb;
    logic [3:0] r_dbits, r_ibits;
    logic [1:0] r_mbits;
    logic [4:0] r_mlat, r_plat;

    // Tag memories: valid bit above the line number.
    logic [TAG_W:0] dmem [MAX_LINES];
    logic [TAG_W:0] imem [MAX_LINES];
    logic [TAG_W:0] r_drd, r_ird;

    logic [1:0]       r_state, n_state;
    logic [IDX_W-1:0] r_clr, n_clr;
    t_item            r_cur, n_cur;

    t_entry r_rb, n_rb, r_fb, n_fb;
    t_entry r_wb [WB_ENTRIES+1];
    t_entry n_wb [WB_ENTRIES+1];

    logic [BUSY_W-1:0] r_busy, n_busy;
    logic [WIN_W-1:0]  r_win, n_win;
    logic              r_dir, n_dir;
    logic [15:0]       r_breq, n_breq;

    logic signed [6:0] r_avail [MAX_MODULES];
    logic signed [6:0] n_avail [MAX_MODULES];
    logic [18:0]       r_page  [MAX_MODULES];
    logic [18:0]       n_page  [MAX_MODULES];
    logic [15:0]       r_mreq  [MAX_MODULES];
    logic [15:0]       n_mreq  [MAX_MODULES];
    logic              r_kst   [MAX_MODULES];
    logic              n_kst   [MAX_MODULES];

    logic [15:0] r_rcnt, n_rcnt, r_fin, n_fin;

    logic        r_ovalid, n_ovalid;
    logic        r_ohit, n_ohit;
    logic [15:0] r_oid, n_oid, r_ofin, n_ofin;

    logic             dwe, iwe;
    logic [IDX_W-1:0] dwa, iwa, d_ra, i_ra;
    logic [TAG_W:0]   dwd, iwd;
    logic             pop;

    // Read addresses follow the queue head; the data is registered and used in the next cycle.
    always_comb begin
        d_ra = cache_idx(line_of(i_hd.addr, r_lb), r_dbits);
        i_ra = cache_idx(line_of(i_hd.addr, r_lb), r_ibits);
    end

    always_ff @(posedge i_clk) begin
        if (dwe) begin
            dmem[dwa] <= dwd;
        end
        if (iwe) begin
            imem[iwa] <= iwd;
        end
        r_drd <= dmem[d_ra];
        r_ird <= imem[i_ra];
    end

    always_comb begin
        t_item             x;
        logic              exec, need_look, data, found, h, extra, conf;
        logic [TAG_W-1:0]  line;
        logic [TAG_W-1:0]  l_rb, l_fb, l_wb;
        logic [TAG_W:0]    word;
        logic [WB_IDX_W-1:0] slot;
        logic [MOD_W-1:0]  mask, m;
        logic [WIN_W-1:0]  wm;
        t_entry            e;
        logic [17:0]       page;
        logic [4:0]        lat;
        logic [2:0]        elb;

        n_state = r_state; n_clr = r_clr; n_cur = r_cur;
        n_rb = r_rb; n_fb = r_fb;
        for (int i = 0; i <= WB_ENTRIES; i++) begin
            n_wb[i] = r_wb[i];
        end
        n_busy = r_busy; n_win = r_win; n_dir = r_dir; n_breq = r_breq;
        for (int i = 0; i < MAX_MODULES; i++) begin
            n_avail[i] = r_avail[i];
            n_page[i]  = r_page[i];
            n_mreq[i]  = r_mreq[i];
            n_kst[i]   = r_kst[i];
        end
        n_rcnt = r_rcnt; n_fin = r_fin;
        n_ovalid = r_ovalid && !i_m_axis_tready;
        n_ohit = r_ohit; n_oid = r_oid; n_ofin = r_ofin;
        dwe = 1'b0; iwe = 1'b0;
        dwa = r_clr; iwa = r_clr;
        dwd = '0; iwd = '0;
        pop = 1'b0; exec = 1'b0;
        mask = mod_mask(r_mbits);
        elb  = (r_lb < 3'd2) ? 3'd2 : r_lb;
        l_rb = line_of(r_rb.addr, r_lb);
        l_fb = line_of(r_fb.addr, r_lb);
        l_wb = line_of(r_wb[0].addr, r_lb);
        x = i_hd;
        need_look = ((i_hd.op == OP_LOAD) && r_den) || ((i_hd.op == OP_FETCH) && r_ien);
        found = 1'b0; h = 1'b0; conf = 1'b0; extra = 1'b0; data = 1'b0;
        slot = WB_IDX_W'(WB_ENTRIES);
        line = '0; word = '0; m = '0; wm = '0; e = r_rb; page = '0; lat = '0;

        unique case (r_state)
            S_CLR: begin
                dwe = 1'b1; iwe = 1'b1;
                n_clr = r_clr + 1'b1;
                if (r_clr == IDX_W'(MAX_LINES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_hd_valid && (!r_ovalid || i_m_axis_tready)) begin
                    pop = 1'b1;
                    if (need_look) begin
                        n_cur   = i_hd;
                        n_state = S_LOOK;
                    end else begin
                        exec = 1'b1;
                    end
                end
            end
            S_LOOK: begin
                x = r_cur;
                exec = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (exec) begin
            n_ovalid = 1'b1;
            n_ohit = 1'b1; n_oid = '0; n_ofin = '0;
            priority if (x.op == OP_TICK) begin
                n_ohit = 1'b0;
                n_ofin = r_fin;
                priority if (r_busy > BUSY_W'(1)) begin
                    n_busy = r_busy - 1'b1;
                end else if (r_busy == BUSY_W'(1)) begin
                    if (r_dir == DIR_TO_CPU && r_breq == r_rb.req &&
                        r_rb.status == ST_PENDING) begin
                        n_fin = r_breq;
                        line = l_rb;
                        dwe = 1'b1; dwa = cache_idx(line, r_dbits); dwd = {1'b1, line};
                        n_rb.status = ST_CLEAR;
                    end else if (r_dir == DIR_TO_CPU && r_breq == r_fb.req &&
                                 r_fb.status == ST_PENDING) begin
                        n_fin = r_breq;
                        line = l_fb;
                        iwe = 1'b1; iwa = cache_idx(line, r_ibits); iwd = {1'b1, line};
                        n_fb.status = ST_CLEAR;
                    end else if (r_dir == DIR_TO_MEM && r_breq == r_wb[0].req &&
                                 r_wb[0].status == ST_PENDING) begin
                        for (int i = 1; i <= WB_ENTRIES; i++) begin
                            n_wb[i-1] = r_wb[i];
                        end
                        n_wb[WB_ENTRIES].status = ST_CLEAR;
                        n_fin = (n_wb[WB_ENTRIES-1].status == ST_READY) ?
                                n_wb[WB_ENTRIES-1].req : 16'd0;
                        if (n_wb[0].status == ST_CLEAR && r_rb.status == ST_BLOCKED) begin
                            n_rb.status = ST_READY;
                        end
                    end
                    n_busy = '0;
                end else if (r_win != WIN_NONE) begin
                    if (r_win == WIN_READ || r_win == WIN_FETCH || r_win == WIN_WRITE) begin
                        e     = (r_win == WIN_READ) ? r_rb :
                                (r_win == WIN_FETCH) ? r_fb : r_wb[0];
                        extra = (r_win == WIN_WRITE);
                        line  = line_of(e.addr, r_lb);
                        m     = line[MOD_W-1:0] & mask;
                        page  = e.addr[31:14];
                        n_busy = BUSY_W'(extra);
                        n_breq = e.req;
                        n_dir  = DIR_TO_MEM;
                        lat = (r_page[m] == {1'b0, page}) ? r_plat : r_mlat;
                        n_avail[m] = signed'(7'(lat) + 7'(extra) + 7'd1);
                        n_page[m]  = {1'b0, page};
                        n_kst[m]   = extra;
                        if (!extra) begin
                            n_mreq[m] = e.req;
                        end
                        if (r_win == WIN_READ) begin
                            n_rb.status = ST_PENDING;
                        end else if (r_win == WIN_FETCH) begin
                            n_fb.status = ST_PENDING;
                        end else begin
                            n_wb[0].status = ST_PENDING;
                        end
                    end else begin
                        wm = r_win - WIN_MOD0;
                        // A reply grant for a module beyond the interleave is dropped.
                        if (r_win >= WIN_MOD0 && wm <= WIN_W'(mask)) begin
                            n_busy = BUSY_W'((7'd1 << (elb - 3'd2)) - 7'd1);
                            n_breq = r_mreq[wm[MOD_W-1:0]];
                            n_dir  = DIR_TO_CPU;
                            n_avail[wm[MOD_W-1:0]] = -7'sd1;
                        end
                    end
                    n_win = WIN_NONE;
                end else begin
                    priority if (r_rb.status == ST_READY &&
                        r_avail[l_rb[MOD_W-1:0] & mask] < 0) begin
                        n_win = WIN_READ;
                    end else if (r_fb.status == ST_READY &&
                        r_avail[l_fb[MOD_W-1:0] & mask] < 0) begin
                        n_win = WIN_FETCH;
                    end else if (r_wb[0].status == ST_READY &&
                        r_avail[l_wb[MOD_W-1:0] & mask] < 0) begin
                        n_win = WIN_WRITE;
                    end else begin
                        for (int i = MAX_MODULES - 1; i >= 0; i--) begin
                            if (MOD_W'(i) <= mask && r_avail[i] == 7'sd0) begin
                                n_win = WIN_MOD0 + WIN_W'(i);
                            end
                        end
                    end
                end
                for (int i = 0; i < MAX_MODULES; i++) begin
                    if (MOD_W'(i) <= mask) begin
                        if (n_avail[i] > 7'sd1) begin
                            n_avail[i] = n_avail[i] - 7'sd1;
                        end else if (n_avail[i] == 7'sd1) begin
                            n_avail[i] = n_kst[i] ? -7'sd1 : 7'sd0;
                        end
                    end
                end
            end else if (x.op == OP_STORE) begin
                if (r_den) begin
                    for (int i = 0; i < WB_ENTRIES; i++) begin
                        if (!found && r_wb[i].status == ST_CLEAR) begin
                            found = 1'b1;
                            slot  = WB_IDX_W'(i);
                        end
                    end
                    if (!found) begin
                        // Buffer full: the overflow slot is taken and a number handed out.
                        n_ohit = 1'b0;
                        n_rcnt = r_rcnt + 16'd1;
                        n_oid  = n_rcnt;
                        n_wb[slot].req = n_rcnt;
                    end
                    n_wb[slot].addr   = x.addr;
                    n_wb[slot].status = ST_READY;
                end
            end else begin
                data = (x.op == OP_LOAD);
                if (data ? r_den : r_ien) begin
                    line = line_of(x.addr, r_lb);
                    word = data ? r_drd : r_ird;
                    h = word[TAG_W] && (word[TAG_W-1:0] == line);
                    if (!h) begin
                        for (int i = 0; i < WB_ENTRIES; i++) begin
                            if (r_wb[i].status != ST_CLEAR &&
                                line_of(r_wb[i].addr, r_lb) == line) begin
                                conf = 1'b1;
                            end
                        end
                        n_ohit = 1'b0;
                        n_rcnt = r_rcnt + 16'd1;
                        n_oid  = n_rcnt;
                        if (data) begin
                            n_rb.addr   = x.addr;
                            n_rb.status = conf ? ST_BLOCKED : ST_READY;
                            n_rb.req    = n_rcnt;
                        end else begin
                            n_fb.addr   = x.addr;
                            n_fb.status = ST_READY;
                            n_fb.req    = n_rcnt;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_cur   <= '0;
            r_rb    <= '0;
            r_fb    <= '0;
            for (int i = 0; i <= WB_ENTRIES; i++) begin
                r_wb[i] <= '0;
            end
            r_busy <= '0; r_win <= WIN_NONE; r_dir <= DIR_TO_CPU; r_breq <= '0;
            for (int i = 0; i < MAX_MODULES; i++) begin
                r_avail[i] <= -7'sd1;
                r_page[i]  <= '1;
                r_mreq[i]  <= '0;
                r_kst[i]   <= 1'b1;
            end
            r_rcnt <= '0; r_fin <= '0;
            r_ovalid <= 1'b0;
            r_den <= 1'b0; r_ien <= 1'b0; r_lb <= 3'd5; r_dbits <= 4'd9;
            r_ibits <= 4'd9; r_mbits <= 2'd0; r_mlat <= 5'd9; r_plat <= 5'd2;
        end else begin
            r_state <= n_state; r_clr <= n_clr; r_cur <= n_cur;
            r_rb <= n_rb; r_fb <= n_fb;
            for (int i = 0; i <= WB_ENTRIES; i++) begin
                r_wb[i] <= n_wb[i];
            end
            r_busy <= n_busy; r_win <= n_win; r_dir <= n_dir; r_breq <= n_breq;
            for (int i = 0; i < MAX_MODULES; i++) begin
                r_avail[i] <= n_avail[i];
                r_page[i]  <= n_page[i];
                r_mreq[i]  <= n_mreq[i];
                r_kst[i]   <= n_kst[i];
            end
            r_rcnt <= n_rcnt; r_fin <= n_fin;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_DEN:   r_den   <= i_cfg_data[0];
                    CFG_IEN:   r_ien   <= i_cfg_data[0];
                    CFG_LINE:  r_lb    <= i_cfg_data[2:0];
                    CFG_DBITS: r_dbits <= i_cfg_data[3:0];
                    CFG_IBITS: r_ibits <= i_cfg_data[3:0];
                    CFG_MBITS: r_mbits <= i_cfg_data[1:0];
                    CFG_MLAT:  r_mlat  <= i_cfg_data;
                    CFG_PLAT:  r_plat  <= i_cfg_data;
                    default:   r_den   <= r_den;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ohit <= n_ohit;
        r_oid  <= n_oid;
        r_ofin <= n_ofin;
    end

    assign o_ctrl.pop       = pop;
    assign o_ctrl.clearing  = (r_state == S_CLR);
    assign o_m_axis_tvalid  = r_ovalid;
    assign o_m_axis_tdata   = {7'd0, r_ofin, r_oid, r_ohit};

    // A lookup only starts with the result register free, so it never waits on it.
    `CBM_ASSERT_IMP(a_look_out_free, i_clk, i_rst_n, r_state == S_LOOK, !r_ovalid)
    `CBM_ASSERT_IMP(a_no_pop_clear, i_clk, i_rst_n, r_state == S_CLR, !pop)
    `CBM_ASSERT_IMP(a_busy_no_win, i_clk, i_rst_n, r_busy != '0, r_win == WIN_NONE)
    `CBM_ASSERT_NXT(a_look_done, i_clk, i_rst_n, r_state == S_LOOK, r_ovalid)

endmodule

>>> design/cache_bus_memory_timing_model_top.sv
// ----------------------------------------------------------------------------
// cache_bus_memory_timing_model_top
// Timing model of write-through caches, buffers, a split bus and memory modules.
// ----------------------------------------------------------------------------
//  Channel    Direction  Contents (lowest bit first)
//  s_axis     in         op[1:0], addr[33:2]
//  m_axis     out        access_hit[0], request_id[16:1], finished_id[32:17]
//  cfg        in         register index, write data
//
// A tick, a store or an access to a disabled cache is executed straight from the
// queue head in the back end; a load or fetch to an enabled cache first passes
// a lookup state, as the tag memory read is registered. After reset a clearing pass
// writes every tag entry invalid, and no transfer is taken meanwhile. A two-entry
// queue lets the input keep flowing while a result waits on a stalled output.
module cache_bus_memory_timing_model_top #(
    parameter int WB_ENTRIES = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,  // op, addr
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,  // access_hit, request_id, finished_id
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [4:0]  i_cfg_data
);
    import cbm_pkg::*;

    t_bk_ctrl ctrl;
    t_item    hd;
    logic     hd_valid;

    cbm_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_ctrl          (ctrl),
        .o_hd_valid      (hd_valid),
        .o_hd            (hd)
    );

    cbm_back #(.WB_ENTRIES(WB_ENTRIES)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_hd_valid      (hd_valid),
        .i_hd            (hd),
        .o_ctrl          (ctrl),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule
